// File: hw/rtl/hrb_pkg.sv
// Shared types for the hex record parser: result words and the push bundle into the result queue.
package hrb_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [31:0] byte_offset;
        logic [7:0]  data_value;
        logic [31:0] start_address;
        logic        success;
        logic        last_of_run;
    } result_t;

    // Up to two result words are produced by one character.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: hw/rtl/hrb_in_if.sv
// Channel interfaces for the hex record parser: text characters in, result words out.
interface hrb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface hrb_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] byte_offset;
    logic [7:0]  data_value;
    logic [31:0] start_address;
    logic        success;
    logic        last_of_run;

    modport source (output valid, output kind, output byte_offset, output data_value,
                    output start_address, output success, output last_of_run,
                    input ready);
    modport sink (input valid, input kind, input byte_offset, input data_value,
                  input start_address, input success, input last_of_run,
                  output ready);
endinterface

// File: hw/rtl/hrb_core.sv
// Character register, line parser state and per-character decode logic.
module hrb_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_char,
    input  logic           in_eot,
    input  logic           room,
    output hrb_pkg::push_t push
);
    import hrb_pkg::*;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] REC_DATA   = 8'h00;
    localparam logic [7:0] REC_END    = 8'h01;
    localparam logic [7:0] REC_EXT    = 8'h04;

    typedef enum logic [2:0] {
        PH_WAIT, PH_HEAD, PH_DHI, PH_DLO_OK, PH_DLO_BAD, PH_EXT, PH_SKIP
    } phase_t;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
            else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
            else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
            return {(c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
                    || (c >= 8'h61 && c <= 8'h66), t[3:0]};
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Input character register
    logic       ivalid_reg;
    logic [7:0] char_reg;
    logic       eot_reg;
    logic       go;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] acc_reg, acc_next;
    logic [3:0]  nib_reg, nib_next;
    logic [31:0] upper_reg, upper_next;
    logic [31:0] first_reg, first_next;
    logic        seen_reg, seen_next;
    logic        placed_reg, placed_next;
    logic        fin_reg, fin_next;
    logic [31:0] base_reg, base_next;

    logic [4:0]  hx;
    logic [15:0] acc_shift;
    logic [7:0]  pos_inc;
    logic [8:0]  pos_wide;
    logic        emit_data;
    logic        emit_sum;
    result_t     data_word;
    result_t     sum_word;

    assign go       = ivalid_reg && room;
    assign in_ready = !ivalid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ivalid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= in_char;
            eot_reg  <= in_eot;
        end
    end

    assign hx        = hex_decode(char_reg);
    assign acc_shift = {acc_reg[11:0], hx[3:0]};
    assign pos_inc   = pos_reg + 8'd1;
    assign pos_wide  = {1'b0, pos_reg} + 9'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        acc_next    = acc_reg;
        nib_next    = nib_reg;
        upper_next  = upper_reg;
        first_next  = first_reg;
        seen_next   = seen_reg;
        placed_next = placed_reg;
        fin_next    = fin_reg;
        base_next   = base_reg;
        emit_data   = 1'b0;
        emit_sum    = 1'b0;

        if (go && !fin_reg)
        begin
            if (char_reg == CHAR_LF)
            begin
                if (phase_reg == PH_EXT)
                    upper_next = {acc_reg, 16'h0000};
                phase_next = PH_WAIT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        if (!is_space(char_reg))
                        begin
                            if (char_reg == CHAR_COLON)
                            begin
                                phase_next = PH_HEAD;
                                pos_next   = 8'd0;
                                acc_next   = 16'h0000;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_HEAD:
                    begin
                        if (!hx[4])
                        begin
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            acc_next = acc_shift;
                            pos_next = pos_inc;
                            if (pos_inc == 8'd2)
                            begin
                                len_next = acc_shift[7:0];
                                acc_next = 16'h0000;
                            end
                            else if (pos_inc == 8'd6)
                            begin
                                off_next = acc_shift;
                                acc_next = 16'h0000;
                            end
                            else if (pos_inc == 8'd8)
                            begin
                                acc_next = 16'h0000;
                                pos_next = 8'd0;
                                if (acc_shift[7:0] == REC_DATA)
                                begin
                                    // The first data record fixes the origin of all offsets.
                                    if (!seen_reg)
                                    begin
                                        first_next = upper_reg + {16'h0000, off_reg};
                                        seen_next  = 1'b1;
                                        base_next  = 32'h0000_0000;
                                    end
                                    else
                                    begin
                                        base_next = upper_reg + {16'h0000, off_reg} - first_reg;
                                    end
                                    phase_next = (len_reg != 8'd0) ? PH_DHI : PH_SKIP;
                                end
                                else if (acc_shift[7:0] == REC_END)
                                begin
                                    phase_next = PH_SKIP;
                                    emit_sum   = 1'b1;
                                end
                                else if (acc_shift[7:0] == REC_EXT)
                                begin
                                    phase_next = PH_EXT;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                    end
                    PH_DHI:
                    begin
                        nib_next   = hx[4] ? hx[3:0] : nib_reg;
                        phase_next = hx[4] ? PH_DLO_OK : PH_DLO_BAD;
                    end
                    PH_DLO_OK, PH_DLO_BAD:
                    begin
                        if (phase_reg == PH_DLO_OK && hx[4])
                        begin
                            emit_data   = 1'b1;
                            placed_next = 1'b1;
                        end
                        pos_next   = pos_wide[7:0];
                        phase_next = (pos_wide >= {1'b0, len_reg}) ? PH_SKIP : PH_DHI;
                    end
                    PH_EXT:
                    begin
                        if (hx[4])
                        begin
                            acc_next = acc_shift;
                            pos_next = pos_inc;
                            if (pos_inc >= 8'd4)
                            begin
                                upper_next = {acc_shift, 16'h0000};
                                phase_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            upper_next = is_space(char_reg) ? {acc_reg, 16'h0000} : 32'h0;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        phase_next = PH_SKIP;
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end

            if (eot_reg)
            begin
                emit_sum   = 1'b1;
                phase_next = PH_WAIT;
            end
            if (emit_sum)
                fin_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            pos_reg    <= 8'd0;
            len_reg    <= 8'd0;
            off_reg    <= 16'h0000;
            acc_reg    <= 16'h0000;
            nib_reg    <= 4'h0;
            upper_reg  <= 32'h0;
            first_reg  <= 32'h0;
            seen_reg   <= 1'b0;
            placed_reg <= 1'b0;
            fin_reg    <= 1'b0;
            base_reg   <= 32'h0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            off_reg    <= off_next;
            acc_reg    <= acc_next;
            nib_reg    <= nib_next;
            upper_reg  <= upper_next;
            first_reg  <= first_next;
            seen_reg   <= seen_next;
            placed_reg <= placed_next;
            fin_reg    <= fin_next;
            base_reg   <= base_next;
        end
    end

    always_comb
    begin
        data_word.kind          = 1'b0;
        data_word.byte_offset   = base_reg + {24'h000000, pos_reg};
        data_word.data_value    = {nib_reg, hx[3:0]};
        data_word.start_address = 32'h0;
        data_word.success       = 1'b0;
        data_word.last_of_run   = !emit_sum;

        sum_word.kind          = 1'b1;
        sum_word.byte_offset   = 32'h0;
        sum_word.data_value    = 8'h00;
        sum_word.start_address = placed_next ? first_next : 32'h0;
        sum_word.success       = placed_next;
        sum_word.last_of_run   = 1'b1;

        push.count  = {1'b0, emit_data} + {1'b0, emit_sum};
        push.first  = emit_data ? data_word : sum_word;
        push.second = sum_word;
    end

endmodule

// File: hw/rtl/hrb_queue.sv
// Four-word result queue that takes up to two words per cycle and hands out one per cycle while out_ready is high.
module hrb_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hrb_pkg::push_t          push,
    output logic                    room,
    output logic [hrb_pkg::LEVEL_W-1:0] level,
    output logic                    out_valid,
    input  logic                    out_ready,
    output hrb_pkg::result_t        out_word
);
    import hrb_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    result_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               pop;

    assign level     = level_reg;
    assign out_valid = level_reg != '0;
    assign pop       = out_valid && out_ready;
    assign room      = level_reg <= LEVEL_W'(QUEUE_DEPTH - 2);
    assign out_word  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            level_reg <= level_reg + LEVEL_W'(push.count) - LEVEL_W'(pop);
        end
    end

endmodule

// File: hw/rtl/hex_record_to_binary_parser.sv
// Top level of the hex record parser: character stage, parser and result queue.
//
// text_in takes one ASCII character of an Intel HEX file per word, with
// end_of_text marking the last one. result_out gives one word per decoded
// data byte (kind 0, offset from the first data record's address) and one
// summary word (kind 1) when an end record or the end of text is seen.
// The last word caused by a character carries last_of_run.
// A character is registered on acceptance and decoded from that register,
// once the queue has room, straight into a four-word result queue that
// drives result_out. One character is taken per cycle as long as the queue
// has room for two words; a character can yield two words, so the sustained
// rate is one word per cycle, set by the queue's single read port. When
// result_out stalls, the queue fills and text_in drops ready once fewer than
// two entries are free while a character is waiting in the input register.
// Reset clears the parser to wait for a line start and empties the queue.
// After the summary every further character is accepted and dropped.
module hex_record_to_binary_parser (
    input  logic      clk,
    input  logic      rst_n,
    hrb_in_if.sink    text_in,
    hrb_out_if.source result_out
);
    import hrb_pkg::*;

    push_t              push;
    logic               room;
    logic [LEVEL_W-1:0] level;
    result_t            out_word;

    hrb_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .in_char  (text_in.text_char),
        .in_eot   (text_in.end_of_text),
        .room     (room),
        .push     (push)
    );

    hrb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .level     (level),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_word  (out_word)
    );

    assign result_out.kind          = out_word.kind;
    assign result_out.byte_offset   = out_word.byte_offset;
    assign result_out.data_value    = out_word.data_value;
    assign result_out.start_address = out_word.start_address;
    assign result_out.success       = out_word.success;
    assign result_out.last_of_run   = out_word.last_of_run;

`ifndef SYNTHESIS
    // The queue never overfills.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> level <= LEVEL_W'(QUEUE_DEPTH - 2))
        else $error("result queue written without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        level <= LEVEL_W'(QUEUE_DEPTH))
        else $error("result queue level out of range");

    // A second word from one character is always the closing summary.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.second.kind && push.second.last_of_run
                               && !push.first.kind && !push.first.last_of_run)
        else $error("bad ordering of a two-word run");

    // A summary word always closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.kind |-> result_out.last_of_run)
        else $error("summary word not marked last");
`endif

endmodule

// File: tb/sv/hrb_result_check.sv
`timescale 1ns / 1ps
// Record codes for the testbench and the checker that predicts and compares parser result words.
package hex_text_pkg;

    localparam logic [7:0] REC_DATA  = 8'h00;
    localparam logic [7:0] REC_END   = 8'h01;
    localparam logic [7:0] REC_UPPER = 8'h04;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

endpackage

module hrb_result_check (
    input  logic clk,
    input  logic rst_n,
    hrb_in_if    text_in,
    hrb_out_if   result_out,
    output int   mismatches,
    output int   words_outstanding,
    output int   words_checked
);
    import hrb_pkg::*;
    import hex_text_pkg::*;

    typedef enum logic [2:0] {
        LINE_WAIT,
        LINE_HEADER,
        PAIR_HIGH,
        PAIR_LOW_OK,
        PAIR_LOW_BAD,
        UPPER_FIELD,
        LINE_SKIP
    } line_phase_e;

    line_phase_e phase;
    logic [15:0] char_pos;
    logic [7:0]  rec_len;
    logic [15:0] rec_offset;
    logic [7:0]  rec_type;
    logic [15:0] field_acc;
    logic [3:0]  high_nibble;
    logic [31:0] upper_base;
    logic [31:0] first_addr;
    logic        first_seen;
    logic        data_placed;
    logic        parse_done;
    result_t     predicted_words[$];
    result_t     want_word;

    function automatic int hex_digit(logic [7:0] c);
        // ASCII ranges 0-9, A-F and a-f.
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        return -1;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic result_t summary_word();
        result_t w;
        w = '0;
        w.kind = KIND_SUMMARY;
        w.start_address = data_placed ? first_addr : 32'h0;
        w.success = data_placed;
        return w;
    endfunction

    // A pending upper address field takes effect when its line ends.
    task automatic end_line();
        if (phase == UPPER_FIELD)
        begin
            upper_base = {field_acc, 16'h0000};
        end
        phase = LINE_WAIT;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic eot);
        result_t words[$];
        result_t w;
        int      d;
        if (!parse_done)
        begin
            d = hex_digit(c);
            if (c == CH_LF)
            begin
                end_line();
            end
            else
            begin
                case (phase)
                    LINE_WAIT:
                    begin
                        if (c == CH_COLON)
                        begin
                            phase = LINE_HEADER;
                            char_pos = '0;
                            field_acc = '0;
                        end
                        else if (!is_blank(c))
                        begin
                            phase = LINE_SKIP;
                        end
                    end
                    LINE_HEADER:
                    begin
                        if (d < 0)
                        begin
                            phase = LINE_SKIP;
                        end
                        else
                        begin
                            field_acc = {field_acc[11:0], d[3:0]};
                            char_pos++;
                            if (char_pos == 16'd2)
                            begin
                                rec_len = field_acc[7:0];
                                field_acc = '0;
                            end
                            else if (char_pos == 16'd6)
                            begin
                                rec_offset = field_acc;
                                field_acc = '0;
                            end
                            else if (char_pos == 16'd8)
                            begin
                                rec_type = field_acc[7:0];
                                field_acc = '0;
                                char_pos = '0;
                                if (rec_type == REC_DATA)
                                begin
                                    // The first data record fixes the base even with no bytes.
                                    if (!first_seen)
                                    begin
                                        first_addr = upper_base + {16'h0000, rec_offset};
                                        first_seen = 1'b1;
                                    end
                                    phase = (rec_len != 8'h00) ? PAIR_HIGH : LINE_SKIP;
                                end
                                else if (rec_type == REC_END)
                                begin
                                    phase = LINE_SKIP;
                                    words.push_back(summary_word());
                                    parse_done = 1'b1;
                                end
                                else if (rec_type == REC_UPPER)
                                begin
                                    phase = UPPER_FIELD;
                                end
                                else
                                begin
                                    phase = LINE_SKIP;
                                end
                            end
                        end
                    end
                    PAIR_HIGH:
                    begin
                        if (d >= 0)
                        begin
                            high_nibble = d[3:0];
                            phase = PAIR_LOW_OK;
                        end
                        else
                        begin
                            phase = PAIR_LOW_BAD;
                        end
                    end
                    PAIR_LOW_OK, PAIR_LOW_BAD:
                    begin
                        // A broken pair places nothing but still uses up its index.
                        if (phase == PAIR_LOW_OK && d >= 0)
                        begin
                            w = '0;
                            w.kind = KIND_DATA;
                            w.byte_offset = upper_base + {16'h0000, rec_offset} - first_addr
                                            + {16'h0000, char_pos};
                            w.data_value = {high_nibble, d[3:0]};
                            words.push_back(w);
                            data_placed = 1'b1;
                        end
                        char_pos++;
                        phase = (char_pos >= {8'h00, rec_len}) ? LINE_SKIP : PAIR_HIGH;
                    end
                    UPPER_FIELD:
                    begin
                        if (d >= 0)
                        begin
                            field_acc = {field_acc[11:0], d[3:0]};
                            char_pos++;
                            if (char_pos >= 16'd4)
                            begin
                                upper_base = {field_acc, 16'h0000};
                                phase = LINE_SKIP;
                            end
                        end
                        else
                        begin
                            upper_base = is_blank(c) ? {field_acc, 16'h0000} : 32'h0;
                            phase = LINE_SKIP;
                        end
                    end
                    default:
                    begin
                        phase = LINE_SKIP;
                    end
                endcase
            end
            if (eot && !parse_done)
            begin
                end_line();
                words.push_back(summary_word());
                parse_done = 1'b1;
            end
            if (words.size() > 0)
            begin
                words[words.size() - 1].last_of_run = 1'b1;
            end
            foreach (words[i])
            begin
                predicted_words.push_back(words[i]);
            end
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        $display("MISMATCH at word %0d: %s expected 0x%0h, got 0x%0h",
                 words_checked, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = LINE_WAIT;
            char_pos = '0;
            rec_len = '0;
            rec_offset = '0;
            rec_type = '0;
            field_acc = '0;
            high_nibble = '0;
            upper_base = '0;
            first_addr = '0;
            first_seen = 1'b0;
            data_placed = 1'b0;
            parse_done = 1'b0;
            predicted_words.delete();
            mismatches = 0;
            words_checked = 0;
            words_outstanding = 0;
        end
        else
        begin
            if (text_in.valid && text_in.ready)
            begin
                parse_char(text_in.text_char, text_in.end_of_text);
            end
            if (result_out.valid && result_out.ready)
            begin
                if (predicted_words.size() == 0)
                begin
                    flag_mismatch("word with none predicted, kind", 32'h0,
                                  32'(result_out.kind));
                end
                else
                begin
                    want_word = predicted_words.pop_front();
                    if (result_out.kind !== want_word.kind)
                        flag_mismatch("kind", 32'(want_word.kind), 32'(result_out.kind));
                    if (result_out.byte_offset !== want_word.byte_offset)
                        flag_mismatch("byte_offset", want_word.byte_offset,
                                      result_out.byte_offset);
                    if (result_out.data_value !== want_word.data_value)
                        flag_mismatch("data_value", 32'(want_word.data_value),
                                      32'(result_out.data_value));
                    if (result_out.start_address !== want_word.start_address)
                        flag_mismatch("start_address", want_word.start_address,
                                      result_out.start_address);
                    if (result_out.success !== want_word.success)
                        flag_mismatch("success", 32'(want_word.success),
                                      32'(result_out.success));
                    if (result_out.last_of_run !== want_word.last_of_run)
                        flag_mismatch("last_of_run", 32'(want_word.last_of_run),
                                      32'(result_out.last_of_run));
                end
                words_checked++;
            end
            words_outstanding = predicted_words.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the hex record parser: clock, reset, hex text stimulus, stalls and verdict.
module tb;
    import hex_text_pkg::*;

    localparam int RANDOM_CHARS = 1700;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    typedef enum {
        ALWAYS_READY,
        HALF_READY,
        MOSTLY_STALLED,
        EVERY_THIRD_STALLED
    } sink_mode_e;

    typedef enum {
        END_RECORD,
        END_RECORD_WITH_EOT,
        EOT_MID_DATA
    } ending_e;

    logic       clk;
    logic       rst_n;
    int         mismatches;
    int         words_outstanding;
    int         words_checked;
    int         idle_cycles;
    text_item_t hex_text[$];
    ending_e    ending;

    hrb_in_if  text_in ();
    hrb_out_if result_out ();

    hex_record_to_binary_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .result_out (result_out)
    );

    hrb_result_check result_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .text_in           (text_in),
        .result_out        (result_out),
        .mismatches        (mismatches),
        .words_outstanding (words_outstanding),
        .words_checked     (words_checked)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void put_char(logic [7:0] c, logic eot);
        text_item_t t;
        t.ch = c;
        t.eot = eot;
        hex_text.push_back(t);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], 1'b0);
    endfunction

    // Letters come out in either case.
    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    function automatic void put_hex(logic [31:0] value, int digits);
        for (int i = digits - 1; i >= 0; i--)
            put_char(hex_char(value[i * 4 +: 4]), 1'b0);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 4))
            0: return 8'h09;
            1: return 8'h0B;
            2: return 8'h0C;
            3: return CH_CR;
            default: return 8'h20;
        endcase
    endfunction

    // Any byte that is not a hex digit and does not end the line.
    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(8'h80, 8'hFF));
            1: return 8'($urandom_range(8'h47, 8'h60));
            2: return 8'($urandom_range(8'h67, 8'h7F));
            3: return 8'($urandom_range(8'h0B, 8'h2F));
            4: return 8'($urandom_range(8'h00, 8'h09));
            default: return 8'($urandom_range(8'h3A, 8'h40));
        endcase
    endfunction

    function automatic void add_random_line();
        int          pick;
        int          count;
        int          pairs;
        int          digits;
        logic [7:0]  rtype;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2)) put_char(blank_char(), 1'b0);
        end
        if (pick < 55)
        begin
            // Data record; long counts are mostly cut short by the line end.
            count = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
            pairs = (count > 16) ? $urandom_range(0, 20) : count;
            if (count <= 16 && $urandom_range(0, 7) == 0)
                pairs = $urandom_range(0, count);
            put_char(CH_COLON, 1'b0);
            put_hex(count, 2);
            put_hex($urandom_range(0, 65535), 4);
            put_hex(32'(REC_DATA), 2);
            for (int i = 0; i < pairs; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            put_char(non_hex_char(), 1'b0);
                            put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
                        end
                        1:
                        begin
                            put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
                            put_char(non_hex_char(), 1'b0);
                        end
                        default:
                        begin
                            put_char(non_hex_char(), 1'b0);
                            put_char(non_hex_char(), 1'b0);
                        end
                    endcase
                end
                else
                begin
                    put_hex($urandom_range(0, 255), 2);
                end
            end
            if (pairs < count && $urandom_range(0, 2) == 0)
                put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
            else if (pairs >= count)
                put_hex($urandom_range(0, 255), 2 * $urandom_range(1, 2));
        end
        else if (pick < 67)
        begin
            put_char(CH_COLON, 1'b0);
            put_hex(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 2, 2);
            put_hex(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0, 4);
            put_hex(32'(REC_UPPER), 2);
            digits = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 4;
            put_hex($urandom_range(0, 65535), digits);
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    put_char(blank_char(), 1'b0);
                    put_hex($urandom_range(0, 255), 2);
                end
                2: put_char(8'($urandom_range(8'h47, 8'h60)), 1'b0);
                default: put_hex($urandom_range(0, 255), 2);
            endcase
        end
        else if (pick < 75)
        begin
            do
                rtype = 8'($urandom_range(0, 255));
            while (rtype == REC_DATA || rtype == REC_END || rtype == REC_UPPER);
            put_char(CH_COLON, 1'b0);
            put_hex($urandom_range(0, 4), 2);
            put_hex($urandom_range(0, 65535), 4);
            put_hex(32'(rtype), 2);
            repeat ($urandom_range(0, 6)) put_hex($urandom_range(0, 255), 2);
        end
        else if (pick < 85)
        begin
            // Header that breaks off or holds a bad character.
            put_char(CH_COLON, 1'b0);
            put_hex($urandom, $urandom_range(0, 7));
            if ($urandom_range(0, 1) == 1)
            begin
                put_char(non_hex_char(), 1'b0);
                put_hex($urandom, $urandom_range(0, 8));
            end
        end
        else if (pick < 95)
        begin
            put_char(($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h80, 8'hFF))
                                                 : 8'($urandom_range(8'h3B, 8'h7E)), 1'b0);
            repeat ($urandom_range(0, 10))
            begin
                c = 8'($urandom_range(0, 255));
                put_char((c == CH_LF) ? 8'h00 : c, 1'b0);
            end
        end
        if ($urandom_range(0, 2) == 0)
            put_char(CH_CR, 1'b0);
        put_char(CH_LF, 1'b0);
    endfunction

    // Idle watchdog: a run that stops moving ends as a failure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((text_in.valid && text_in.ready) || (result_out.valid && result_out.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: stall patterns picked at random, each held for a random span, plus one long hold-off.
    initial
    begin
        int         cycle;
        int         hold;
        int         mode_left;
        sink_mode_e mode;
        cycle = 0;
        hold = 0;
        mode_left = 0;
        mode = ALWAYS_READY;
        result_out.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle == HOLD_START)
                hold = HOLD_CYCLES;
            if (hold > 0)
            begin
                hold--;
                result_out.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = sink_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                case (mode)
                    ALWAYS_READY:   result_out.ready <= 1'b1;
                    HALF_READY:     result_out.ready <= ($urandom_range(0, 1) == 1);
                    MOSTLY_STALLED: result_out.ready <= ($urandom_range(0, 4) == 0);
                    default:        result_out.ready <= (cycle % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        int pos;
        int burst_left;
        int gap_left;
        int directed_len;
        rst_n = 1'b0;
        text_in.valid = 1'b0;
        text_in.text_char = 8'h00;
        text_in.end_of_text = 1'b0;

        // Junk line with extreme bytes, a count-zero first data record, then a record
        // whose first byte wraps the offset, a broken pair and a lone trailing digit.
        put_char(8'hFF, 1'b0);
        put_char(8'h00, 1'b0);
        put_char(CH_LF, 1'b0);
        put_str(" :00FFFF00\n");
        put_str(":03FFFE00fFg10\n");
        directed_len = hex_text.size();
        while (hex_text.size() < directed_len + RANDOM_CHARS)
            add_random_line();

        ending = ending_e'($urandom_range(0, 2));
        case (ending)
            END_RECORD:
            begin
                put_str(":00000001FF\n");
            end
            END_RECORD_WITH_EOT:
            begin
                put_str(":0000000");
                put_char("1", 1'b1);
            end
            default:
            begin
                // The final character completes a pair, so it yields a byte and the summary.
                put_str(":04");
                put_hex($urandom_range(0, 65535), 4);
                put_str("00ABc");
                put_char("D", 1'b1);
            end
        endcase
        // Everything after the summary is taken and dropped.
        repeat (8) put_char(8'($urandom_range(0, 255)), ($urandom_range(0, 2) == 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        pos = 0;
        burst_left = $urandom_range(1, 30);
        gap_left = 0;
        while (pos < hex_text.size())
        begin
            @(negedge clk);
            if (gap_left > 0)
            begin
                gap_left--;
                text_in.valid <= 1'b0;
            end
            else
            begin
                text_in.valid <= 1'b1;
                text_in.text_char <= hex_text[pos].ch;
                text_in.end_of_text <= hex_text[pos].eot;
            end
            @(posedge clk);
            if (text_in.valid && text_in.ready)
            begin
                pos++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 3);
                        default:    gap_left = $urandom_range(4, 12);
                    endcase
                end
            end
        end
        @(negedge clk);
        text_in.valid <= 1'b0;

        wait (words_outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d characters: junk and blank lines, broken headers and pairs,",
                 hex_text.size());
        $display("upper-address and other records; %0d result words checked, ending %s.",
                 words_checked, ending.name());
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/hrb_pkg.sv
hw/rtl/hrb_in_if.sv
hw/rtl/hrb_core.sv
hw/rtl/hrb_queue.sv
hw/rtl/hex_record_to_binary_parser.sv
tb/sv/hrb_result_check.sv
tb/sv/tb.sv
